// ===== hdl/pcxrle_pkg.sv =====
`default_nettype none

package pcxrle_pkg;

   localparam int MAX_LINE_DEF = 2048;
   localparam int PLANES       = 3;

   localparam int DATA_W     = 8;
   localparam int COL_OUT_W  = 11;
   localparam int ROW_W      = 16;
   localparam int WIDTH_W    = 12;
   localparam int HEIGHT_W   = 17;
   localparam int PLB_W      = 12;
   localparam int COUNT_W    = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_LINE_BYTES = 2'd2;

   localparam logic [DATA_W-1:0]   RUN_MARK       = 8'hC0;
   localparam logic [DATA_W-1:0]   RUN_COUNT_MASK = 8'h3F;
   localparam logic [HEIGHT_W-1:0] HEIGHT_MAX     = 17'h10000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PLACE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PLANE_RED,
      PLANE_GREEN,
      PLANE_BLUE
   } plane_type;

   typedef struct packed {
      logic accept;
      logic place;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic go_place;
      logic place_emit;
      logic place_finish;
      logic emit_finish;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

// ===== hdl/pcx_truecolor_rle_line_decoder.sv =====
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | req_data_byte
// rsp     | out       | rsp_valid/rsp_ready  | rgb, pixel_column/row, row/image_done, run_last
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data
//
// A run header is only accepted; a literal or run value is accepted, then each decoded
// byte is placed on the line in the place state, and each emitted pixel adds an emit
// state that loads the output register from the line store read.
// The line store holds the red and green planes, each with one write and one read port.
// A pixel waits in its staging register while the output register is full.
// Reset clears control state and sets the size registers to their defaults; the line store is not cleared.
`default_nettype none

module pcx_truecolor_rle_line_decoder
   import pcxrle_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_ready,
   input  wire  [DATA_W-1:0]     req_data_byte,
   output logic                  rsp_valid,
   input  wire                   rsp_ready,
   output logic [DATA_W-1:0]     rsp_red,
   output logic [DATA_W-1:0]     rsp_green,
   output logic [DATA_W-1:0]     rsp_blue,
   output logic [COL_OUT_W-1:0]  rsp_pixel_column,
   output logic [ROW_W-1:0]      rsp_pixel_row,
   output logic                  rsp_row_done,
   output logic                  rsp_image_done,
   output logic                  rsp_run_last,
   input  wire                   csr_valid,
   output logic                  csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   pcxrle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pcxrle_dp #(
      .MAX_LINE (MAX_LINE)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_data_byte    (req_data_byte),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_row_done     (rsp_row_done),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_last     (rsp_run_last)
   );

   // output register is only reloaded once its item has gone
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register overwritten");

   // an emitting placement holds off new items while the pixel is pending
   a_no_accept_after_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.place && sts.place_emit) |=> !req_ready)
      else $error("item accepted with a pixel pending");

   a_image_implies_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_image_done) |-> rsp_row_done)
      else $error("image end off a row end");

   // nothing visible follows the last column within the same item
   a_row_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_row_done) |-> rsp_run_last)
      else $error("row end not marked last of item");

endmodule

`default_nettype wire

// ===== hdl/pcxrle_ctrl.sv =====
`default_nettype none

module pcxrle_ctrl
   import pcxrle_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   input  wire          req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && sts.go_place) begin
               state_in = ST_PLACE;
            end
         end
         ST_PLACE: begin
            if (sts.place_emit) begin
               state_in = ST_EMIT;
            end else if (sts.place_finish) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = sts.emit_finish ? ST_IDLE : ST_PLACE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.accept   = 1'b0;
      cmd.place    = 1'b0;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_PLACE: begin
            cmd.place = 1'b1;
         end
         ST_EMIT: begin
            cmd.out_load = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/pcxrle_dp.sv =====
`default_nettype none

module pcxrle_dp
   import pcxrle_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire  cmd_type         cmd,
   output sts_type               sts,
   input  wire                   csr_valid,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data,
   input  wire  [DATA_W-1:0]     req_data_byte,
   input  wire                   rsp_ready,
   output logic                  rsp_valid,
   output logic [DATA_W-1:0]     rsp_red,
   output logic [DATA_W-1:0]     rsp_green,
   output logic [DATA_W-1:0]     rsp_blue,
   output logic [COL_OUT_W-1:0]  rsp_pixel_column,
   output logic [ROW_W-1:0]      rsp_pixel_row,
   output logic                  rsp_row_done,
   output logic                  rsp_image_done,
   output logic                  rsp_run_last
);

   localparam int PW    = $clog2(MAX_LINE + 1);
   localparam int COL_W = $clog2(MAX_LINE);
   localparam int LP_W  = $clog2(PLANES * MAX_LINE + 1);

   // raw registers
   logic [WIDTH_W-1:0]  iw_ff, iw_in;
   logic [HEIGHT_W-1:0] ih_ff, ih_in;
   logic [PLB_W-1:0]    plb_ff, plb_in;

   // clamped geometry, registered from the raw registers and following them in the next cycle
   logic [PW-1:0]       p_ff, p_in;
   logic [PW-1:0]       w_ff, w_in;
   logic [LP_W-1:0]     two_p_ff, two_p_in;
   logic [LP_W-1:0]     len_ff, len_in;
   logic [HEIGHT_W-1:0] h_ff, h_in;
   logic [31:0]         plb_wide, iw_wide, p_wide, w_wide;

   // decoder state
   logic                awaiting_ff, awaiting_in;
   logic [COUNT_W-1:0]  pending_ff, pending_in;
   logic [COUNT_W-1:0]  rem_ff, rem_in;
   logic [DATA_W-1:0]   value_ff, value_in;
   logic [LP_W-1:0]     lp_ff, lp_in;
   logic [ROW_W-1:0]    row_ff, row_in;

   // pixel staged between placement and output load
   logic [COL_OUT_W-1:0] st_col_ff, st_col_in;
   logic [ROW_W-1:0]     st_row_ff, st_row_in;
   logic                 st_row_done_ff, st_row_done_in;
   logic                 st_img_done_ff, st_img_done_in;
   logic                 st_run_last_ff, st_run_last_in;
   logic                 st_finish_ff, st_finish_in;
   logic [DATA_W-1:0]    st_blue_ff, st_blue_in;

   // output register
   logic                 out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]    out_red_ff, out_red_in;
   logic [DATA_W-1:0]    out_green_ff, out_green_in;
   logic [DATA_W-1:0]    out_blue_ff, out_blue_in;
   logic [COL_OUT_W-1:0] out_col_ff, out_col_in;
   logic [ROW_W-1:0]     out_row_ff, out_row_in;
   logic                 out_row_done_ff, out_row_done_in;
   logic                 out_img_done_ff, out_img_done_in;
   logic                 out_run_last_ff, out_run_last_in;

   // line store, red and green planes
   logic [DATA_W-1:0] red_mem [MAX_LINE];
   logic [DATA_W-1:0] green_mem [MAX_LINE];
   logic [DATA_W-1:0] red_rd_ff;
   logic [DATA_W-1:0] green_rd_ff;

   // placement step
   logic                is_header;
   logic [LP_W-1:0]     lp_n, lp_inc, colw, p_lp, w_lp;
   logic [ROW_W-1:0]    row_n;
   logic [HEIGHT_W-1:0] row_inc;
   plane_type           plane;
   logic [COL_W-1:0]    col_idx;
   logic                emit, last_col, row_last, line_end, rem_one;

   always_comb begin
      iw_in  = iw_ff;
      ih_in  = ih_ff;
      plb_in = plb_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:      iw_in  = csr_data[WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT:     ih_in  = csr_data[HEIGHT_W-1:0];
            CSR_PLANE_LINE_BYTES: plb_in = csr_data[PLB_W-1:0];
            default:              iw_in  = iw_ff;
         endcase
      end
   end

   always_comb begin
      plb_wide = 32'(plb_ff);
      iw_wide  = 32'(iw_ff);
      if (plb_wide == 32'd0) begin
         p_wide = 32'd1;
      end else if (plb_wide > 32'(MAX_LINE)) begin
         p_wide = 32'(MAX_LINE);
      end else begin
         p_wide = plb_wide;
      end
      w_wide   = (iw_wide > p_wide) ? p_wide : iw_wide;
      p_in     = PW'(p_wide);
      w_in     = PW'(w_wide);
      two_p_in = LP_W'(p_wide << 1);
      len_in   = LP_W'(p_wide * 32'(PLANES));
      h_in     = (ih_ff == '0 || ih_ff > HEIGHT_MAX) ? HEIGHT_MAX : ih_ff;
   end

   always_comb begin
      lp_n  = (lp_ff >= len_ff) ? '0 : lp_ff;
      row_n = ({1'b0, row_ff} >= h_ff) ? '0 : row_ff;
      p_lp  = LP_W'(p_ff);
      w_lp  = LP_W'(w_ff);
      if (lp_n < p_lp) begin
         plane = PLANE_RED;
         colw  = lp_n;
      end else if (lp_n < two_p_ff) begin
         plane = PLANE_GREEN;
         colw  = lp_n - p_lp;
      end else begin
         plane = PLANE_BLUE;
         colw  = lp_n - two_p_ff;
      end
      col_idx  = colw[COL_W-1:0];
      emit     = (plane == PLANE_BLUE) && (colw < w_lp);
      last_col = (colw + LP_W'(1)) == w_lp;
      row_inc  = {1'b0, row_n} + HEIGHT_W'(1);
      row_last = row_inc == h_ff;
      lp_inc   = lp_n + LP_W'(1);
      line_end = lp_inc == len_ff;
      rem_one  = rem_ff == COUNT_W'(1);
   end

   assign is_header = (req_data_byte & RUN_MARK) == RUN_MARK;

   always_comb begin
      awaiting_in = awaiting_ff;
      pending_in  = pending_ff;
      rem_in      = rem_ff;
      value_in    = value_ff;
      lp_in       = lp_ff;
      row_in      = row_ff;

      st_col_in      = st_col_ff;
      st_row_in      = st_row_ff;
      st_row_done_in = st_row_done_ff;
      st_img_done_in = st_img_done_ff;
      st_run_last_in = st_run_last_ff;
      st_finish_in   = st_finish_ff;
      st_blue_in     = st_blue_ff;

      if (cmd.accept) begin
         if (awaiting_ff) begin
            awaiting_in = 1'b0;
            pending_in  = '0;
            rem_in      = pending_ff;
            value_in    = req_data_byte;
         end else if (is_header) begin
            awaiting_in = 1'b1;
            pending_in  = COUNT_W'(req_data_byte & RUN_COUNT_MASK);
         end else begin
            rem_in   = COUNT_W'(1);
            value_in = req_data_byte;
         end
      end

      if (cmd.place) begin
         rem_in = rem_ff - COUNT_W'(1);
         if (line_end) begin
            lp_in  = '0;
            row_in = row_last ? '0 : row_inc[ROW_W-1:0];
         end else begin
            lp_in  = lp_inc;
            row_in = row_n;
         end
         if (emit) begin
            st_col_in      = COL_OUT_W'(colw);
            st_row_in      = row_n;
            st_row_done_in = last_col;
            st_img_done_in = last_col && row_last;
            // no later byte of this run lands on a visible column
            st_run_last_in = last_col || rem_one;
            st_finish_in   = line_end || rem_one;
            st_blue_in     = value_ff;
         end
      end
   end

   always_comb begin
      out_valid_in    = out_valid_ff;
      out_red_in      = out_red_ff;
      out_green_in    = out_green_ff;
      out_blue_in     = out_blue_ff;
      out_col_in      = out_col_ff;
      out_row_in      = out_row_ff;
      out_row_done_in = out_row_done_ff;
      out_img_done_in = out_img_done_ff;
      out_run_last_in = out_run_last_ff;
      if (cmd.out_load) begin
         out_valid_in    = 1'b1;
         out_red_in      = red_rd_ff;
         out_green_in    = green_rd_ff;
         out_blue_in     = st_blue_ff;
         out_col_in      = st_col_ff;
         out_row_in      = st_row_ff;
         out_row_done_in = st_row_done_ff;
         out_img_done_in = st_img_done_ff;
         out_run_last_in = st_run_last_ff;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place && plane == PLANE_RED) begin
         red_mem[col_idx] <= value_ff;
      end
      if (cmd.place && emit) begin
         red_rd_ff <= red_mem[col_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.place && plane == PLANE_GREEN) begin
         green_mem[col_idx] <= value_ff;
      end
      if (cmd.place && emit) begin
         green_rd_ff <= green_mem[col_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iw_ff        <= WIDTH_W'(640);
         ih_ff        <= HEIGHT_W'(480);
         plb_ff       <= PLB_W'(640);
         awaiting_ff  <= 1'b0;
         pending_ff   <= '0;
         rem_ff       <= '0;
         lp_ff        <= '0;
         row_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         iw_ff        <= iw_in;
         ih_ff        <= ih_in;
         plb_ff       <= plb_in;
         awaiting_ff  <= awaiting_in;
         pending_ff   <= pending_in;
         rem_ff       <= rem_in;
         lp_ff        <= lp_in;
         row_ff       <= row_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff            <= p_in;
      w_ff            <= w_in;
      two_p_ff        <= two_p_in;
      len_ff          <= len_in;
      h_ff            <= h_in;
      value_ff        <= value_in;
      st_col_ff       <= st_col_in;
      st_row_ff       <= st_row_in;
      st_row_done_ff  <= st_row_done_in;
      st_img_done_ff  <= st_img_done_in;
      st_run_last_ff  <= st_run_last_in;
      st_finish_ff    <= st_finish_in;
      st_blue_ff      <= st_blue_in;
      out_red_ff      <= out_red_in;
      out_green_ff    <= out_green_in;
      out_blue_ff     <= out_blue_in;
      out_col_ff      <= out_col_in;
      out_row_ff      <= out_row_in;
      out_row_done_ff <= out_row_done_in;
      out_img_done_ff <= out_img_done_in;
      out_run_last_ff <= out_run_last_in;
   end

   always_comb begin
      sts.go_place     = awaiting_ff ? (pending_ff != '0) : !is_header;
      sts.place_emit   = emit;
      sts.place_finish = line_end || rem_one;
      sts.emit_finish  = st_finish_ff;
      sts.out_free     = !out_valid_ff || rsp_ready;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_red          = out_red_ff;
   assign rsp_green        = out_green_ff;
   assign rsp_blue         = out_blue_ff;
   assign rsp_pixel_column = out_col_ff;
   assign rsp_pixel_row    = out_row_ff;
   assign rsp_row_done     = out_row_done_ff;
   assign rsp_image_done   = out_img_done_ff;
   assign rsp_run_last     = out_run_last_ff;

endmodule

`default_nettype wire

// ===== bench/pcx_pixel_checker.sv =====
module pcx_pixel_checker
   import pcxrle_pkg::*;
(
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  wire                   req_ready,
   input  wire  [DATA_W-1:0]     req_data_byte,
   input  wire                   rsp_valid,
   input  wire                   rsp_ready,
   input  wire  [DATA_W-1:0]     rsp_red,
   input  wire  [DATA_W-1:0]     rsp_green,
   input  wire  [DATA_W-1:0]     rsp_blue,
   input  wire  [COL_OUT_W-1:0]  rsp_pixel_column,
   input  wire  [ROW_W-1:0]      rsp_pixel_row,
   input  wire                   rsp_row_done,
   input  wire                   rsp_image_done,
   input  wire                   rsp_run_last,
   input  wire                   csr_valid,
   input  wire                   csr_ready,
   input  wire  [CSR_IDX_W-1:0]  csr_index,
   input  wire  [CSR_DATA_W-1:0] csr_data,
   output int                    mismatches,
   output int                    pending_pixels,
   output int                    pixels_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [DATA_W-1:0]    red;
      logic [DATA_W-1:0]    green;
      logic [DATA_W-1:0]    blue;
      logic [COL_OUT_W-1:0] column;
      logic [ROW_W-1:0]     row;
      logic                 row_done;
      logic                 image_done;
      logic                 run_last;
   } pixel_type;

   // red plane at 0, green plane at MAX_LINE_DEF
   logic [DATA_W-1:0]   rg_store [0:(PLANES-1)*MAX_LINE_DEF-1];
   logic [WIDTH_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0] height_reg;
   logic [PLB_W-1:0]    plb_reg;
   int unsigned         line_pos;
   int unsigned         row_pos;
   bit                  run_pending;
   logic [COUNT_W-1:0]  run_len;
   pixel_type           expected_pixels [$];
   pixel_type           held;
   bit                  have_held;
   pixel_type           want_px;
   pixel_type           got_px;
   int                  errors;
   int                  checked;

   initial begin
      mismatches = 0;
      pending_pixels = 0;
      pixels_checked = 0;
      errors = 0;
      checked = 0;
   end

   // one decoded byte onto the scan line; line_over set when the line wraps
   task place_decoded(input logic [DATA_W-1:0] v, output bit line_over);
      int unsigned p;
      int unsigned len;
      int unsigned h;
      int unsigned w;
      int unsigned col;
      int unsigned plane;
      pixel_type   px;
      p = (plb_reg == 0) ? 1 : ((plb_reg > MAX_LINE_DEF) ? MAX_LINE_DEF : 32'(plb_reg));
      len = PLANES * p;
      h = 32'((height_reg == 0 || height_reg > HEIGHT_MAX) ? HEIGHT_MAX : height_reg);
      w = (32'(width_reg) < p) ? 32'(width_reg) : p;
      if (line_pos >= len) line_pos = 0;
      if (row_pos >= h) row_pos = 0;
      col = line_pos;
      plane = 0;
      while (col >= p && plane < PLANES - 1) begin
         col = col - p;
         plane++;
      end
      if (plane < PLANES - 1) begin
         rg_store[plane * MAX_LINE_DEF + col] = v;
      end else if (col < w) begin
         px.red        = rg_store[col];
         px.green      = rg_store[MAX_LINE_DEF + col];
         px.blue       = v;
         px.column     = col[COL_OUT_W-1:0];
         px.row        = row_pos[ROW_W-1:0];
         px.row_done   = (col + 1 == w);
         px.image_done = px.row_done && (row_pos + 1 == h);
         px.run_last   = 1'b0;
         // hold back one pixel so the last of the item can be tagged
         if (have_held) expected_pixels = {expected_pixels, held};
         held = px;
         have_held = 1'b1;
      end
      line_pos++;
      line_over = 1'b0;
      if (line_pos >= len) begin
         line_pos = 0;
         row_pos++;
         if (row_pos >= h) row_pos = 0;
         line_over = 1'b1;
      end
   endtask

   task decode_item(input logic [DATA_W-1:0] b);
      bit                over;
      int unsigned       i;
      logic [DATA_W-1:0] masked;
      have_held = 1'b0;
      over = 1'b0;
      if (run_pending) begin
         run_pending = 1'b0;
         i = 0;
         while (i < run_len && !over) begin
            place_decoded(b, over);
            i++;
         end
         run_len = '0;
      end else if ((b & RUN_MARK) == RUN_MARK) begin
         masked = b & RUN_COUNT_MASK;
         run_len = masked[COUNT_W-1:0];
         run_pending = 1'b1;
      end else begin
         place_decoded(b, over);
      end
      if (have_held) begin
         held.run_last = 1'b1;
         expected_pixels = {expected_pixels, held};
      end
   endtask

   task check_field(input string name, input logic [ROW_W-1:0] want, input logic [ROW_W-1:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg   = 12'd640;
         height_reg  = 17'd480;
         plb_reg     = 12'd640;
         line_pos    = 0;
         row_pos     = 0;
         run_pending = 1'b0;
         run_len     = '0;
         expected_pixels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:      width_reg  = csr_data[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT:     height_reg = csr_data[HEIGHT_W-1:0];
               CSR_PLANE_LINE_BYTES: plb_reg    = csr_data[PLB_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            checked++;
            got_px = {rsp_red, rsp_green, rsp_blue, rsp_pixel_column, rsp_pixel_row,
                      rsp_row_done, rsp_image_done, rsp_run_last};
            if (expected_pixels.size() == 0) begin
               errors++;
               $display("%0t: unexpected pixel, expected none, got col %0d row %0d rgb %h%h%h",
                        $time, rsp_pixel_column, rsp_pixel_row, rsp_red, rsp_green, rsp_blue);
            end else begin
               want_px = expected_pixels.pop_front();
               check_field("red", ROW_W'(want_px.red), ROW_W'(got_px.red));
               check_field("green", ROW_W'(want_px.green), ROW_W'(got_px.green));
               check_field("blue", ROW_W'(want_px.blue), ROW_W'(got_px.blue));
               check_field("pixel_column", ROW_W'(want_px.column), ROW_W'(got_px.column));
               check_field("pixel_row", want_px.row, got_px.row);
               check_field("row_done", ROW_W'(want_px.row_done), ROW_W'(got_px.row_done));
               check_field("image_done", ROW_W'(want_px.image_done),
                           ROW_W'(got_px.image_done));
               check_field("run_last", ROW_W'(want_px.run_last), ROW_W'(got_px.run_last));
            end
         end
         if (req_valid && req_ready) decode_item(req_data_byte);
      end
      mismatches     <= errors;
      pending_pixels <= expected_pixels.size();
      pixels_checked <= checked;
   end

endmodule

// ===== bench/tb_pcx_truecolor_rle_line_decoder.sv =====
module tb_pcx_truecolor_rle_line_decoder;
   timeunit 1ns;
   timeprecision 1ps;
   import pcxrle_pkg::*;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   wire                   req_ready;
   logic [DATA_W-1:0]     req_data_byte = '0;
   wire                   rsp_valid;
   logic                  rsp_ready = 1'b0;
   wire  [DATA_W-1:0]     rsp_red;
   wire  [DATA_W-1:0]     rsp_green;
   wire  [DATA_W-1:0]     rsp_blue;
   wire  [COL_OUT_W-1:0]  rsp_pixel_column;
   wire  [ROW_W-1:0]      rsp_pixel_row;
   wire                   rsp_row_done;
   wire                   rsp_image_done;
   wire                   rsp_run_last;
   logic                  csr_valid = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int                    mismatches;
   int                    pending_pixels;
   int                    pixels_checked;

   // stimulus bookkeeping: effective plane length and decoded position in the line
   int unsigned           plane_bytes = 640;
   int unsigned           pos = 0;
   int unsigned           items_sent = 0;
   int unsigned           reg_writes = 0;
   bit                    req_quiet = 1'b0;
   bit                    rsp_quiet = 1'b0;
   int unsigned           rsp_wait = 0;

   pcx_truecolor_rle_line_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_row_done     (rsp_row_done),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   pcx_pixel_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_row_done     (rsp_row_done),
      .rsp_image_done   (rsp_image_done),
      .rsp_run_last     (rsp_run_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatches       (mismatches),
      .pending_pixels   (pending_pixels),
      .pixels_checked   (pixels_checked)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("tb_pcx_truecolor_rle_line_decoder NOT OK");
      $finish;
   end

   // pixel sink: random stall before each item, with quiet stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else if (rsp_valid && rsp_ready) begin
         if ($urandom_range(0, 15) == 0) rsp_quiet = !rsp_quiet;
         rsp_wait = rsp_quiet ? 0 : $urandom_range(0, 10);
         rsp_ready <= (rsp_wait == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait = rsp_wait - 1;
         rsp_ready <= (rsp_wait == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task send_byte(input logic [DATA_W-1:0] b);
      int unsigned gap;
      if ($urandom_range(0, 19) == 0) req_quiet = !req_quiet;
      gap = req_quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   // count copies of v; a count of 1 below the run mark may go as a plain literal
   task send_decoded(input logic [DATA_W-1:0] v, input int unsigned count, input bit as_literal);
      int unsigned room;
      room = PLANES * plane_bytes - pos;
      if (count == 1 && v < RUN_MARK && as_literal) begin
         send_byte(v);
      end else begin
         send_byte(RUN_MARK | count[DATA_W-1:0]);
         send_byte(v);
      end
      if (count >= room) pos = 0;
      else pos = pos + count;
   endtask

   task fill_line_bytes(input int unsigned total);
      int unsigned left;
      int unsigned room;
      int unsigned reach;
      int unsigned count;
      int unsigned adv;
      left = total;
      while (left > 0) begin
         room = PLANES * plane_bytes - pos;
         reach = (left < room) ? left : room;
         if (reach > 63) reach = 63;
         count = ($urandom_range(0, 2) == 0) ? 1 : $urandom_range(1, reach);
         // a run that reaches the line end may overshoot; the rest is dropped
         if (count == room && $urandom_range(0, 1) == 1) count = $urandom_range(room, 63);
         if ($urandom_range(0, 15) == 0)
            send_decoded(DATA_W'($urandom_range(0, 255)), 0, 1'b0);
         adv = (count < room) ? count : room;
         send_decoded(DATA_W'($urandom_range(0, 255)), count, 1'($urandom_range(0, 1)));
         left = (left > adv) ? left - adv : 0;
      end
   endtask

   // mask bit n selects register index n; junk goes into the unused upper bits
   task set_config(input logic [2:0] mask, input logic [WIDTH_W-1:0] w,
                   input logic [HEIGHT_W-1:0] h, input logic [PLB_W-1:0] p);
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] junk;
      idx = CSR_IMAGE_WIDTH;
      repeat (3) begin
         if (mask[idx]) begin
            junk = CSR_DATA_W'($urandom);
            csr_valid <= 1'b1;
            csr_index <= idx;
            case (idx)
               CSR_IMAGE_WIDTH:  csr_data <= {junk[CSR_DATA_W-1:WIDTH_W], w};
               CSR_IMAGE_HEIGHT: csr_data <= h;
               default:          csr_data <= {junk[CSR_DATA_W-1:PLB_W], p};
            endcase
            @(posedge clock);
            while (!csr_ready) @(posedge clock);
            reg_writes++;
         end
         idx++;
      end
      csr_valid <= 1'b0;
      if (mask[CSR_PLANE_LINE_BYTES]) begin
         plane_bytes = (p == 0) ? 1 : ((p > MAX_LINE_DEF) ? MAX_LINE_DEF : 32'(p));
         if (pos >= PLANES * plane_bytes) pos = 0;
      end
   endtask

   task wait_for_pixels();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_pixels != 0);
      // a run placing only red/green bytes finishes without any pixel
      repeat (150) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [2:0]  mask;
      int unsigned p_new;
      int unsigned pb;
      int unsigned w_new;
      int unsigned h_new;
      int unsigned big_runs;
      big_runs = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // 4-byte planes, 3 pixels wide, two rows
      set_config(3'b111, 12'd3, 17'd2, 12'd4);
      send_decoded(8'h00, 1, 1'b1);
      send_decoded(8'hBF, 1, 1'b1);
      send_decoded(8'hFF, 2, 1'b0);
      send_decoded(8'h80, 4, 1'b0);
      send_decoded(8'h01, 1, 1'b1);
      send_decoded(8'h55, 0, 1'b0);
      send_decoded(8'hC5, 3, 1'b0);
      send_decoded(8'h7E, 63, 1'b0);
      wait_for_pixels();
      // zero width: a line is counted but nothing comes out
      set_config(3'b001, 12'd0, 17'd2, 12'd4);
      send_decoded(8'h11, 12, 1'b0);
      wait_for_pixels();
      // clamps: width above plane length, plane length 0, height 0
      set_config(3'b111, 12'hFFF, 17'd0, 12'd0);
      send_decoded(8'h22, 1, 1'b1);
      send_decoded(8'h33, 1, 1'b1);
      send_decoded(8'hC0, 1, 1'b0);
      wait_for_pixels();
      // shrink the line mid-way so the position restarts, and the height below the row
      set_config(3'b100, 12'hFFF, 17'd0, 12'd6);
      send_decoded(8'h5A, 10, 1'b0);
      wait_for_pixels();
      set_config(3'b110, 12'hFFF, 17'd1, 12'd2);
      send_decoded(8'h3C, 6, 1'b0);
      wait_for_pixels();

      while (items_sent < 270) begin
         if (big_runs < 2 && items_sent >= 110 * (big_runs + 1)) begin
            if (pos != 0) begin
               fill_line_bytes(PLANES * plane_bytes - pos);
               wait_for_pixels();
            end
            // longest plane: part of the red plane, then cut the line short
            set_config(3'b111, (big_runs == 0) ? 12'd2048 : 12'hFFF,
                       HEIGHT_W'($urandom_range(1, 4)),
                       (big_runs == 0) ? 12'hFFF : 12'd2048);
            fill_line_bytes($urandom_range(60, 200));
            wait_for_pixels();
            set_config(3'b100, 12'd0, 17'd0, PLB_W'($urandom_range(1, pos / PLANES)));
            big_runs++;
         end else begin
            mask = 3'($urandom_range(1, 7));
            p_new = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10);
            if (pos != 0) begin
               if (pos >= PLANES && $urandom_range(0, 1) == 1)
                  p_new = $urandom_range(0, pos / PLANES);
               else
                  mask[CSR_PLANE_LINE_BYTES] = 1'b0;
            end
            pb = mask[CSR_PLANE_LINE_BYTES] ? ((p_new == 0) ? 1 : p_new) : plane_bytes;
            case ($urandom_range(0, 7))
               0:       w_new = 0;
               1:       w_new = 4095;
               default: w_new = $urandom_range(1, pb + 2);
            endcase
            case ($urandom_range(0, 9))
               0:       h_new = 0;
               1:       h_new = 65536;
               2:       h_new = 131071;
               default: h_new = $urandom_range(1, 4);
            endcase
            if (mask == 0) mask[CSR_IMAGE_WIDTH] = 1'b1;
            set_config(mask, WIDTH_W'(w_new), HEIGHT_W'(h_new), PLB_W'(p_new));
            fill_line_bytes($urandom_range(1, 9 * plane_bytes));
         end
         wait_for_pixels();
      end

      $display("%0d compressed bytes sent over %0d register writes, %0d pixels compared",
               items_sent, reg_writes, pixels_checked);
      $display("covered literals, runs of 0 to 63, line overruns, padding and register clamps");
      if (mismatches == 0)
         $display("tb_pcx_truecolor_rle_line_decoder OK");
      else
         $display("tb_pcx_truecolor_rle_line_decoder NOT OK");
      $finish;
   end

endmodule
